[design/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion forms used by the skinning controller.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is high.
`define LBS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is checked at every edge, reset included.
`define LBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/lbs_pkg.sv]
// ---------------------------------------------------------------------------
// Linear blend skinning package
// Function and pass codes, the controller command word and saturation helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package lbs_pkg;

   localparam int WEIGHT_BITS = 16;

   typedef enum logic [1:0] {
      FUNC_BIND = 2'd0,
      FUNC_INV  = 2'd1,
      FUNC_POSE = 2'd2,
      FUNC_INFL = 2'd3
   } lbs_func_type;

   typedef enum logic [1:0] {
      PASS_BIND   = 2'd0,
      PASS_INV    = 2'd1,
      PASS_POSE   = 2'd2,
      PASS_WEIGHT = 2'd3
   } lbs_pass_type;

   typedef struct packed {
      logic         load;
      logic         start;
      logic         issue;
      lbs_pass_type pass;
      logic [3:0]   idx;
      logic         v_from_res;
      logic         emit;
   } lbs_cmd_type;

   localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] S32_MIN = 64'shFFFF_FFFF_8000_0000;
   localparam logic signed [63:0] S48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] S48_MIN = 64'shFFFF_8000_0000_0000;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > S32_MAX) r = 32'sh7FFF_FFFF;
      else if (v < S32_MIN) r = 32'sh8000_0000;
      else r = $signed(v[31:0]);
      return r;
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
      logic signed [47:0] r;
      if (v > S48_MAX) r = 48'sh7FFF_FFFF_FFFF;
      else if (v < S48_MIN) r = 48'sh8000_0000_0000;
      else r = $signed(v[47:0]);
      return r;
   endfunction

endpackage

`default_nettype wire

[design/lbs_channels.sv]
// ---------------------------------------------------------------------------
// Skinning unit channels
// Request and response valid/ready channels with their payloads.
// ---------------------------------------------------------------------------
`default_nettype none

interface lbs_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic [4:0]         joint;
   logic [3:0]         element;
   logic signed [31:0] value;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic [16:0]        weight_q;
   logic               last_influence;

   modport source (output valid, func, joint, element, value, pos_x, pos_y, pos_z,
                   weight_q, last_influence, input ready);
   modport sink   (input valid, func, joint, element, value, pos_x, pos_y, pos_z,
                   weight_q, last_influence, output ready);
endinterface

interface lbs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_z;

   modport source (output valid, out_x, out_y, out_z, input ready);
   modport sink   (input valid, out_x, out_y, out_z, output ready);
endinterface

`default_nettype wire

[design/linear_blend_skinning_unit.sv]
// ---------------------------------------------------------------------------
// Linear blend skinning unit
// Fixed-point vertex skinning over bind-shape, inverse-bind and pose tables.
// ---------------------------------------------------------------------------
// A load item (func 0 to 2) writes one matrix element and gives no result. An
// influence item (func 3) keeps the unit busy, taking no new item, until it is
// done: one shared 32 by 32 multiplier works through three passes of sixteen
// products, each followed by a drain of the table read and product registers,
// then three weighting products and a final drain. On the last influence of a
// vertex the saturated xyz goes to an output register; a new item is taken
// while that result waits. If the previous result has still not been taken
// when a closing influence reaches its final cycle, the unit holds there until
// it is. Table entries are undefined until written and need no clearing after
// reset.
`default_nettype none

module linear_blend_skinning_unit import lbs_pkg::*; #(
   parameter int MAX_JOINTS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   lbs_req_if.sink   req_ch,
   lbs_rsp_if.source rsp_ch
);

   lbs_cmd_type cmd;

   lbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_func  (req_ch.func),
      .req_last  (req_ch.last_influence),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   lbs_datapath #(
      .MAX_JOINTS (MAX_JOINTS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .func     (req_ch.func),
      .joint    (req_ch.joint),
      .element  (req_ch.element),
      .value    (req_ch.value),
      .pos_x    (req_ch.pos_x),
      .pos_y    (req_ch.pos_y),
      .pos_z    (req_ch.pos_z),
      .weight_q (req_ch.weight_q),
      .out_x    (rsp_ch.out_x),
      .out_y    (rsp_ch.out_y),
      .out_z    (rsp_ch.out_z)
   );

endmodule

`default_nettype wire

[design/lbs_datapath.sv]
// ---------------------------------------------------------------------------
// Skinning datapath
// Matrix tables, shared multiply-accumulate pipeline, accumulator and output.
// ---------------------------------------------------------------------------
`default_nettype none

module lbs_datapath import lbs_pkg::*; #(
   parameter int MAX_JOINTS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lbs_cmd_type        cmd,
   input  wire logic [1:0]         func,
   input  wire logic [4:0]         joint,
   input  wire logic [3:0]         element,
   input  wire logic signed [31:0] value,
   input  wire logic signed [31:0] pos_x,
   input  wire logic signed [31:0] pos_y,
   input  wire logic signed [31:0] pos_z,
   input  wire logic [16:0]        weight_q,
   output logic signed [31:0]      out_x,
   output logic signed [31:0]      out_y,
   output logic signed [31:0]      out_z
);

   localparam int JW    = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
   localparam int DEPTH = MAX_JOINTS * 16;
   localparam int AW    = JW + 4;
   localparam logic signed [31:0] ONE_Q = 32'sh1 << FRAC_BITS;

   // Joint numbers wrap around the table size; built by counting, not dividing.
   function automatic logic [31:0][JW-1:0] build_jmap();
      logic [31:0][JW-1:0] m;
      int r;
      r = 0;
      for (int i = 0; i < 32; i++) begin
         m[i] = JW'(r);
         r = r + 1;
         if (r == MAX_JOINTS) r = 0;
      end
      return m;
   endfunction

   localparam logic [31:0][JW-1:0] JMAP = build_jmap();

   logic signed [31:0] bind_mem [16];
   logic signed [31:0] inv_mem  [DEPTH];
   logic signed [31:0] pose_mem [DEPTH];
   logic signed [31:0] bind_q_ff, inv_q_ff, pose_q_ff;

   logic [JW-1:0]      joint_ff;
   logic [16:0]        weight_ff;
   logic signed [31:0] v_ff   [4];
   logic signed [31:0] res_ff [4];
   logic signed [63:0] sum_ff;
   logic signed [47:0] acc_ff [3];
   logic signed [31:0] out_ff [3];

   logic               p1_valid_ff, p2_valid_ff;
   lbs_pass_type       p1_pass_ff, p2_pass_ff;
   logic [3:0]         p1_idx_ff, p2_idx_ff;
   logic signed [63:0] prod_ff;

   logic [AW-1:0]      wr_addr, rd_addr;
   logic [3:0]         rd_elem;
   logic signed [31:0] mat_q, op_a, op_b;
   logic signed [63:0] prod_in, term_m, term_w, total, acc_sum;
   logic [1:0]         lane;

   // The matrix is walked column by column; element index is row * 4 + column.
   assign rd_elem = {cmd.idx[1:0], cmd.idx[3:2]};
   assign rd_addr = {joint_ff, rd_elem};
   assign wr_addr = {JMAP[joint], element};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         case (lbs_func_type'(func))
            FUNC_BIND: bind_mem[element] <= value;
            FUNC_INV:  inv_mem[wr_addr]  <= value;
            FUNC_POSE: pose_mem[wr_addr] <= value;
            default: ;
         endcase
      end
      bind_q_ff <= bind_mem[rd_elem];
      inv_q_ff  <= inv_mem[rd_addr];
      pose_q_ff <= pose_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         joint_ff  <= JMAP[joint];
         weight_ff <= weight_q;
         v_ff[0]   <= pos_x;
         v_ff[1]   <= pos_y;
         v_ff[2]   <= pos_z;
         v_ff[3]   <= ONE_Q;
      end else if (cmd.v_from_res) begin
         for (int i = 0; i < 4; i++) v_ff[i] <= res_ff[i];
      end
   end

   always_comb begin
      case (p1_pass_ff)
         PASS_BIND: mat_q = bind_q_ff;
         PASS_INV:  mat_q = inv_q_ff;
         default:   mat_q = pose_q_ff;
      endcase
      op_a = v_ff[p1_idx_ff[1:0]];
      op_b = (p1_pass_ff == PASS_WEIGHT) ? $signed({15'b0, weight_ff}) : mat_q;
   end

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= cmd.issue;
         p2_valid_ff <= p1_valid_ff;
      end
      p1_pass_ff <= cmd.pass;
      p1_idx_ff  <= cmd.idx;
      p2_pass_ff <= p1_pass_ff;
      p2_idx_ff  <= p1_idx_ff;
      prod_ff    <= prod_in;
   end

   assign lane    = p2_idx_ff[1:0];
   assign term_m  = prod_ff >>> FRAC_BITS;
   assign term_w  = prod_ff >>> WEIGHT_BITS;
   assign total   = ((lane == 2'd0) ? 64'sd0 : sum_ff) + term_m;
   assign acc_sum = {{16{acc_ff[lane][47]}}, acc_ff[lane]} + term_w;

   always_ff @(posedge clock) begin
      if (p2_valid_ff && p2_pass_ff != PASS_WEIGHT) begin
         sum_ff <= total;
         if (lane == 2'd3) res_ff[p2_idx_ff[3:2]] <= sat32(total);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) acc_ff[i] <= '0;
      end else if (cmd.emit) begin
         for (int i = 0; i < 3; i++) acc_ff[i] <= '0;
      end else if (p2_valid_ff && p2_pass_ff == PASS_WEIGHT) begin
         acc_ff[lane] <= sat48(acc_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         for (int i = 0; i < 3; i++) out_ff[i] <= sat32({{16{acc_ff[i][47]}}, acc_ff[i]});
      end
   end

   assign out_x = out_ff[0];
   assign out_y = out_ff[1];
   assign out_z = out_ff[2];

endmodule

`default_nettype wire

[design/lbs_ctrl.sv]
// ---------------------------------------------------------------------------
// Skinning controller
// Sequences the three matrix passes, the weighting and the result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lbs_ctrl import lbs_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_func,
   input  wire logic       req_last,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output lbs_cmd_type     cmd
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_MAT    = 6'b000010,
      S_DRAIN  = 6'b000100,
      S_WEIGHT = 6'b001000,
      S_WDRAIN = 6'b010000,
      S_FIN    = 6'b100000
   } lbs_state_type;

   lbs_state_type state_ff, state_in;
   lbs_pass_type  pass_ff, pass_in;
   logic [3:0]    idx_ff, idx_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic          last_ff, last_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      last_in  = last_ff;
      cmd      = '0;
      cmd.pass = pass_ff;
      cmd.idx  = idx_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (lbs_func_type'(req_func) == FUNC_INFL) begin
                  cmd.start = 1'b1;
                  last_in   = req_last;
                  pass_in   = PASS_BIND;
                  idx_in    = '0;
                  state_in  = S_MAT;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         S_MAT: begin
            cmd.issue = 1'b1;
            idx_in    = idx_ff + 4'd1;
            if (idx_ff == 4'd15) begin
               state_in = S_DRAIN;
               cnt_in   = '0;
            end
         end
         S_DRAIN: begin
            // Wait until the last column has passed the table read and product registers into the result.
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd2) begin
               cmd.v_from_res = 1'b1;
               cnt_in         = '0;
               idx_in         = '0;
               if (pass_ff == PASS_POSE) begin
                  pass_in  = PASS_WEIGHT;
                  state_in = S_WEIGHT;
               end else begin
                  pass_in  = lbs_pass_type'(pass_ff + 2'd1);
                  state_in = S_MAT;
               end
            end
         end
         S_WEIGHT: begin
            cmd.issue = 1'b1;
            idx_in    = idx_ff + 4'd1;
            if (idx_ff == 4'd2) begin
               state_in = S_WDRAIN;
               cnt_in   = '0;
               idx_in   = '0;
            end
         end
         S_WDRAIN: begin
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd1) state_in = S_FIN;
         end
         S_FIN: begin
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.emit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pass_ff      <= PASS_BIND;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `LBS_ASSERT(a_emit_slot_free, clock, reset, cmd.emit |-> (!rsp_valid_ff || rsp_ready), "result overwritten")
   `LBS_ASSERT(a_emit_shows, clock, reset, cmd.emit |=> rsp_valid_ff, "emitted item not shown")
   `LBS_ASSERT(a_start_pass, clock, reset, cmd.start |=> (state_ff == S_MAT && pass_ff == PASS_BIND && idx_ff == 4'd0), "bad pass start")
   `LBS_ASSERT(a_weight_lanes, clock, reset, (state_ff == S_WEIGHT) |-> (idx_ff <= 4'd2), "weight lane out of range")

endmodule

`default_nettype wire
